[sv/cvfi_pkg.sv]
// Shared types and constants for the credit-based VC flit injector.
// No dependencies; every other file of the block but cvfi_queue imports this package.
package cvfi_pkg;

    // Fixed field widths of the interface.
    localparam int PRIO_W        = 8;
    localparam int NUM_PRIO_REGS = 6;
    localparam int PCOUNT_W      = 3;
    localparam int CREDIT_W      = 5;
    localparam int RETURN_BITS   = 4;
    localparam int SEND_VC_W     = 2;
    localparam int COUNT_W       = 32;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 8;

    // Internal widths, sized for the full range of the module parameters.
    localparam int VC_IDX_W = 3;
    localparam int RANK_W   = 3;

    // Default parameter values.
    localparam int DEF_NUM_VCS   = 4;
    localparam int DEF_NUM_PRIOS = 6;
    localparam int DEF_Q_DEPTH   = 2;

    // Configuration register indexes beyond the priority table.
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_COUNT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LIMIT = 4'd7;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET  = 3'd4;
    localparam logic [CREDIT_W-1:0] LIMIT_RESET   = 5'd4;
    localparam logic [CREDIT_W-1:0] CREDIT_RESET  = 5'd4;
    localparam logic [CREDIT_W-1:0] MAX_CREDITS   = 5'd16;

    typedef struct packed {
        logic [NUM_PRIO_REGS-1:0][PRIO_W-1:0] prio_value;
        logic [PCOUNT_W-1:0]                  prio_count;
        logic [CREDIT_W-1:0]                  credit_limit;
    } t_cfg;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic                   sendable;
        logic                   unknown;
        logic [VC_IDX_W-1:0]    vc;
        logic                   head;
        logic [RETURN_BITS-1:0] returns;
    } t_cls;

endpackage

[sv/credit_vc_flit_injector.sv]
// Throughput: one word per clock cycle while the queue holds words and the
// result is popped. A word is held in the queue, then in the output register.
// Reset (synchronous, active low) empties the queue and the result register,
// loads every VC with four credits, clears the packet counter and restores the
// configuration. Depends on cvfi_pkg, cvfi_front, cvfi_queue and cvfi_back.
module credit_vc_flit_injector #(
    parameter int NUM_VCS   = cvfi_pkg::DEF_NUM_VCS,
    parameter int NUM_PRIOS = cvfi_pkg::DEF_NUM_PRIOS,
    parameter int Q_DEPTH   = cvfi_pkg::DEF_Q_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cvfi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cvfi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_flit_present,
    input  logic [cvfi_pkg::PRIO_W-1:0]       i_flit_priority,
    input  logic                              i_flit_is_head,
    input  logic [cvfi_pkg::RETURN_BITS-1:0]  i_credit_return,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_send,
    output logic [cvfi_pkg::SEND_VC_W-1:0]    o_send_vc,
    output logic                              o_priority_unknown,
    output logic [cvfi_pkg::COUNT_W-1:0]      o_packets_injected
);
    import cvfi_pkg::*;

    // The block splits into a classify front, a short queue of classified
    // words and a credit back end. The front is pure logic: it looks the
    // flit's priority up in the table and maps the rank to a VC. Every
    // accepted word is one tick of the credit state, so the back end
    // consumes queued words strictly in order and updates the counters once
    // per word, whether or not a flit was offered in it.

    t_cfg r_cfg;
    t_cls front_cls, back_cls;
    logic q_empty, q_pop;

    // Configuration registers. Writes to indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PRIO_REGS; i++) begin
                r_cfg.prio_value[i] <= PRIO_W'(i);
            end
            r_cfg.prio_count   <= PCOUNT_RESET;
            r_cfg.credit_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRIO_COUNT: begin
                    r_cfg.prio_count <= i_cfg_data[PCOUNT_W-1:0];
                end
                CFG_CREDIT_LIMIT: begin
                    r_cfg.credit_limit <= i_cfg_data[CREDIT_W-1:0];
                end
                default: begin
                    for (int i = 0; i < NUM_PRIO_REGS; i++) begin
                        if (i_cfg_idx == CFG_IDX_W'(i)) begin
                            r_cfg.prio_value[i] <= i_cfg_data[PRIO_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    cvfi_front #(
        .NUM_VCS   (NUM_VCS),
        .NUM_PRIOS (NUM_PRIOS)
    ) u_front (
        .i_cfg           (r_cfg),
        .i_flit_present  (i_flit_present),
        .i_flit_priority (i_flit_priority),
        .i_flit_is_head  (i_flit_is_head),
        .i_credit_return (i_credit_return),
        .o_cls           (front_cls)
    );

    // The queue's full flag is the input side's back-pressure.
    cvfi_queue #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (back_cls),
        .o_empty (q_empty)
    );

    // The back end holds its result in an output register and takes the next
    // queued word in the same cycle that the current result is popped.
    cvfi_back #(
        .NUM_VCS (NUM_VCS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_credit_limit     (r_cfg.credit_limit),
        .i_q_empty          (q_empty),
        .i_q_data           (back_cls),
        .o_q_pop            (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_send             (o_send),
        .o_send_vc          (o_send_vc),
        .o_priority_unknown (o_priority_unknown),
        .o_packets_injected (o_packets_injected)
    );

    // A flit with an unknown priority is never sent.
    a_unknown_not_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_priority_unknown |-> !o_send)
        else $error("flit with unknown priority was sent");

    // An unknown priority reports VC zero.
    a_unknown_vc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_priority_unknown |-> o_send_vc == '0)
        else $error("unknown priority reported a nonzero VC");

    // Reset leaves both the input and result sides empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("block not empty after reset");

endmodule

[sv/cvfi_queue.sv]
// Small register-based FIFO that decouples the classify and credit stages.
// Generic in width and depth; uses nothing from the package.
module cvfi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[sv/cvfi_front.sv]
// Classify stage: priority table lookup and rank to VC mapping.
// Depends on cvfi_pkg for the configuration and classified word types.
module cvfi_front #(
    parameter int NUM_VCS   = 4,
    parameter int NUM_PRIOS = 6
) (
    input  cvfi_pkg::t_cfg                    i_cfg,
    input  logic                              i_flit_present,
    input  logic [cvfi_pkg::PRIO_W-1:0]       i_flit_priority,
    input  logic                              i_flit_is_head,
    input  logic [cvfi_pkg::RETURN_BITS-1:0]  i_credit_return,
    output cvfi_pkg::t_cls                    o_cls
);
    import cvfi_pkg::*;

    localparam int PROD_W = 7;

    logic [PCOUNT_W-1:0] pc_eff;
    logic [RANK_W-1:0]   rank;
    logic [VC_IDX_W-1:0] vc_map;
    logic [PROD_W-1:0]   rank_scaled;

    always_comb begin
        if (i_cfg.prio_count == '0) begin
            pc_eff = PCOUNT_W'(1);
        end else if (i_cfg.prio_count > PCOUNT_W'(NUM_PRIOS)) begin
            pc_eff = PCOUNT_W'(NUM_PRIOS);
        end else begin
            pc_eff = i_cfg.prio_count;
        end
    end

    // Walk from the top so that the lowest matching rank wins.
    always_comb begin
        rank = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
            if ((i < pc_eff) && (i_cfg.prio_value[i] == i_flit_priority)) begin
                rank = RANK_W'(i + 1);
            end
        end
    end

    // With more priorities than VCs the VC is ceil(rank*V/pc)-1, which equals
    // the number of m in 1..V-1 with m*pc < rank*V; that also clamps to V-1.
    // The count is compared at full integer width, since V may not fit the
    // narrow count field.
    always_comb begin
        rank_scaled = PROD_W'(rank) * PROD_W'(NUM_VCS);
        vc_map      = '0;
        if (int'(pc_eff) <= NUM_VCS) begin
            vc_map = VC_IDX_W'(rank - RANK_W'(1));
        end else begin
            for (int m = 1; m < NUM_VCS; m++) begin
                if (PROD_W'(m) * PROD_W'(pc_eff) < rank_scaled) begin
                    vc_map = vc_map + VC_IDX_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_cls.sendable = i_flit_present && (rank != '0);
        o_cls.unknown  = i_flit_present && (rank == '0);
        o_cls.vc       = o_cls.sendable ? vc_map : '0;
        o_cls.head     = i_flit_is_head;
        o_cls.returns  = i_credit_return;
    end

endmodule

[sv/cvfi_back.sv]
// Credit stage: per-VC credit counters, send decision, packet counter and
// the output register. Depends on cvfi_pkg for the classified word type.
module cvfi_back #(
    parameter int NUM_VCS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [cvfi_pkg::CREDIT_W-1:0]     i_credit_limit,
    input  logic                              i_q_empty,
    input  cvfi_pkg::t_cls                    i_q_data,
    output logic                              o_q_pop,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic                              o_send,
    output logic [cvfi_pkg::SEND_VC_W-1:0]    o_send_vc,
    output logic                              o_priority_unknown,
    output logic [cvfi_pkg::COUNT_W-1:0]      o_packets_injected
);
    import cvfi_pkg::*;

    localparam int RET_W = (NUM_VCS > RETURN_BITS) ? NUM_VCS : RETURN_BITS;
    localparam int SUM_W = CREDIT_W + 1;

    logic [CREDIT_W-1:0] r_credit [NUM_VCS];
    logic [CREDIT_W-1:0] n_credit [NUM_VCS];
    logic [COUNT_W-1:0]  r_pkts, n_pkts;
    logic                r_valid;
    logic                take, avail, send;
    logic [CREDIT_W-1:0] limit;
    logic [RET_W-1:0]    ret_ext;
    logic [SUM_W-1:0]    c;

    assign take    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = take;
    assign o_empty = !r_valid;
    assign ret_ext = RET_W'(i_q_data.returns);

    always_comb begin
        if (i_credit_limit == '0) begin
            limit = CREDIT_W'(1);
        end else if (i_credit_limit > MAX_CREDITS) begin
            limit = MAX_CREDITS;
        end else begin
            limit = i_credit_limit;
        end
    end

    always_comb begin
        avail = 1'b0;
        for (int v = 0; v < NUM_VCS; v++) begin
            avail = avail || ((i_q_data.vc == VC_IDX_W'(v)) && (r_credit[v] != '0));
        end
        send   = i_q_data.sendable && avail;
        n_pkts = r_pkts + COUNT_W'(send && i_q_data.head);
    end

    always_comb begin
        c = '0;
        for (int v = 0; v < NUM_VCS; v++) begin
            c = SUM_W'(r_credit[v]);
            if (send && (i_q_data.vc == VC_IDX_W'(v))) begin
                c = c - SUM_W'(1);
            end
            if (ret_ext[v]) begin
                c = c + SUM_W'(1);
            end
            if (c > SUM_W'(limit)) begin
                c = SUM_W'(limit);
            end
            n_credit[v] = c[CREDIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pkts  <= '0;
            for (int v = 0; v < NUM_VCS; v++) begin
                r_credit[v] <= CREDIT_RESET;
            end
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_pkts  <= n_pkts;
                for (int v = 0; v < NUM_VCS; v++) begin
                    r_credit[v] <= n_credit[v];
                end
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_send             <= send;
            o_send_vc          <= SEND_VC_W'(i_q_data.vc);
            o_priority_unknown <= i_q_data.unknown;
            o_packets_injected <= n_pkts;
        end
    end

endmodule
